### hdl/olad_pkg.sv
package olad_pkg;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SHOW   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int COUNT_W = 5;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] item_value;
   } olad_req_type;

   typedef struct packed {
      logic signed [31:0]  entry_value;
      logic [1:0]          status;
      logic [COUNT_W-1:0]  entry_count;
      logic                last_result;
   } olad_rsp_type;

endpackage

### hdl/olad_front.sv
module olad_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  olad_pkg::olad_req_type req_data,
   output logic                 cmd_valid,
   input  logic                 cmd_pop,
   output olad_pkg::olad_req_type cmd_data
);
   import olad_pkg::*;

   olad_req_type q_ff [2];
   logic         q_wp_ff, q_wp_in;
   logic         q_rp_ff, q_rp_in;
   logic [1:0]   q_cnt_ff, q_cnt_in;
   logic         keep;
   logic         take;

   assign req_full  = (q_cnt_ff == 2'd2);
   assign cmd_valid = (q_cnt_ff != 2'd0);
   assign cmd_data  = q_ff[q_rp_ff];

   // Requests with the unused operation code are accepted and dropped here.
   assign keep = req_push && !req_full && (req_data.operation != OP_UNUSED);
   assign take = cmd_pop && cmd_valid;

   always_comb begin
      q_wp_in  = keep ? ~q_wp_ff : q_wp_ff;
      q_rp_in  = take ? ~q_rp_ff : q_rp_ff;
      q_cnt_in = q_cnt_ff + 2'(keep) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff  <= 1'b0;
         q_rp_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         q_wp_ff  <= q_wp_in;
         q_rp_ff  <= q_rp_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         q_ff[q_wp_ff] <= req_data;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff != 2'd3)
      else $error("command queue count out of range");

   a_no_unused: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> (cmd_data.operation != OP_UNUSED))
      else $error("unused operation reached the command queue head");

   a_drop: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && (req_data.operation == OP_UNUSED) && !take)
      |=> $stable(q_cnt_ff))
      else $error("unused operation changed the queue count");
`endif

endmodule

### hdl/olad_back.sv
module olad_back #(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  olad_pkg::olad_req_type cmd_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output olad_pkg::olad_rsp_type rsp_data
);
   import olad_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SRCH_RD  = 3'd1;
   localparam logic [2:0] S_SRCH_CMP = 3'd2;
   localparam logic [2:0] S_SHIFT_RD = 3'd3;
   localparam logic [2:0] S_SHIFT_WR = 3'd4;
   localparam logic [2:0] S_SHOW_RD  = 3'd5;
   localparam logic [2:0] S_SHOW_OUT = 3'd6;
   localparam logic [2:0] S_EMIT     = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [31:0]        val_ff, val_in;
   olad_rsp_type       res_ff, res_in;
   logic [CW-1:0]      idx_next;
   logic [CW-1:0]      idx_prev;
   logic [CW-1:0]      cnt_inc;
   logic [CW-1:0]      cnt_dec;
   logic               more;

   logic [31:0]        list_mem_ff [CAPACITY];
   logic [31:0]        rd_data_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_wa;
   logic [31:0]        mem_wd;

   olad_rsp_type       rq_ff [2];
   logic               rq_wp_ff, rq_wp_in;
   logic               rq_rp_ff, rq_rp_in;
   logic [1:0]         rq_cnt_ff, rq_cnt_in;
   logic               rsp_full;
   logic               rsp_push;
   olad_rsp_type       rsp_push_data;
   logic               rsp_take;

   assign idx_next = idx_ff + CW'(1);
   assign idx_prev = idx_ff - CW'(1);
   assign cnt_inc  = cnt_ff + CW'(1);
   assign cnt_dec  = cnt_ff - CW'(1);
   assign more     = (idx_next < cnt_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      res_in        = res_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = cnt_ff[IW-1:0];
      mem_wd        = cmd_data.item_value;
      rsp_push      = 1'b0;
      rsp_push_data = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               val_in  = cmd_data.item_value;
               idx_in  = '0;
               case (cmd_data.operation)
                  OP_APPEND: begin
                     state_in = S_EMIT;
                     if (cnt_ff >= CW'(CAPACITY)) begin
                        res_in = '{cmd_data.item_value, ST_FULL, COUNT_W'(cnt_ff), 1'b1};
                     end else begin
                        mem_we = 1'b1;
                        cnt_in = cnt_inc;
                        res_in = '{cmd_data.item_value, ST_OK, COUNT_W'(cnt_inc), 1'b1};
                     end
                  end
                  OP_DELETE: begin
                     if (cnt_ff == '0) begin
                        res_in   = '{cmd_data.item_value, ST_EMPTY, '0, 1'b1};
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  OP_SHOW: begin
                     if (cnt_ff == '0) begin
                        res_in   = '{cmd_data.item_value, ST_EMPTY, '0, 1'b1};
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_SHOW_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (rd_data_ff == val_ff) begin
               if (more) begin
                  idx_in   = idx_next;
                  state_in = S_SHIFT_RD;
               end else begin
                  cnt_in   = cnt_dec;
                  res_in   = '{val_ff, ST_OK, COUNT_W'(cnt_dec), 1'b1};
                  state_in = S_EMIT;
               end
            end else if (more) begin
               idx_in   = idx_next;
               state_in = S_SRCH_RD;
            end else begin
               res_in   = '{val_ff, ST_NOT_FOUND, COUNT_W'(cnt_ff), 1'b1};
               state_in = S_EMIT;
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // Move the entry just read one place toward the head.
            mem_we = 1'b1;
            mem_wa = idx_prev[IW-1:0];
            mem_wd = rd_data_ff;
            if (more) begin
               idx_in   = idx_next;
               state_in = S_SHIFT_RD;
            end else begin
               cnt_in   = cnt_dec;
               res_in   = '{val_ff, ST_OK, COUNT_W'(cnt_dec), 1'b1};
               state_in = S_EMIT;
            end
         end
         S_SHOW_RD: begin
            state_in = S_SHOW_OUT;
         end
         S_SHOW_OUT: begin
            rsp_push_data = '{rd_data_ff, ST_OK, COUNT_W'(cnt_ff), !more};
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (more) begin
                  idx_in   = idx_next;
                  state_in = S_SHOW_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      val_ff <= val_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         list_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= list_mem_ff[idx_ff[IW-1:0]];
   end

   // Two-entry result queue decouples the sequencer from the consumer.
   assign rsp_full  = (rq_cnt_ff == 2'd2);
   assign rsp_empty = (rq_cnt_ff == 2'd0);
   assign rsp_data  = rq_ff[rq_rp_ff];
   assign rsp_take  = rsp_pop && !rsp_empty;

   always_comb begin
      rq_wp_in  = rsp_push ? ~rq_wp_ff : rq_wp_ff;
      rq_rp_in  = rsp_take ? ~rq_rp_ff : rq_rp_ff;
      rq_cnt_in = rq_cnt_ff + 2'(rsp_push) - 2'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wp_ff  <= 1'b0;
         rq_rp_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         rq_wp_ff  <= rq_wp_in;
         rq_rp_ff  <= rq_rp_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rq_wp_ff] <= rsp_push_data;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("fill count exceeds capacity");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SRCH_CMP) || (state_ff == S_SHIFT_WR) || (state_ff == S_SHOW_OUT))
      |-> (idx_ff < cnt_ff))
      else $error("list index beyond fill count");

   a_shift_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_WR) |-> (idx_ff != '0))
      else $error("compaction write below the head");

   a_del_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SHIFT_WR) && !more) |=> (cnt_ff == $past(cnt_dec)))
      else $error("delete did not shrink the list");

   a_rq_push: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rq_cnt_ff != 2'd2))
      else $error("result queue overflow");
`endif

endmodule

### hdl/ordered_list_append_delete_core.sv
// Ordered list of up to CAPACITY signed 32-bit values. Requests enter a
// two-deep command queue (op code 3 is taken and dropped) and are then
// carried out by a sequencer on a list memory with one write and one read
// port and registered read data; results leave through a two-deep result
// queue. The memory ports set the rate. The sequencer takes a request in
// the cycle after its beat, when it is idle. An append writes the memory
// unless the list is full; a delete reads and compares each entry up to the
// match or the end, then moves each later entry one place toward the
// head; a show reads and emits each entry in turn. A result is on
// the result ports from the cycle after the one that hands it to an empty
// result queue. A full result queue stalls the sequencer until a beat is
// popped. No clearing pass is needed after reset.
module ordered_list_append_delete_core #(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  olad_pkg::olad_req_type req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output olad_pkg::olad_rsp_type rsp_data
);
   import olad_pkg::*;

   logic         cmd_valid;
   logic         cmd_pop;
   olad_req_type cmd_data;

   olad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   olad_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
